>>> sv/lla_pkg.sv
// Shared constants, types and codes of the life-like automaton step unit.
package lla_pkg;

   // grid geometry and neighborhood
   localparam int GRID_HEIGHT = 64;
   localparam int GRID_WIDTH  = 64;
   localparam int RADIUS      = 1;
   localparam int WIN_ROWS    = 2 * RADIUS + 1;
   localparam int LANE_W      = GRID_WIDTH + 2 * RADIUS;
   localparam int CELLS       = GRID_HEIGHT * GRID_WIDTH;
   localparam int NBR_MAX     = WIN_ROWS * WIN_ROWS - 1;

   localparam int ROW_AW  = $clog2(GRID_HEIGHT);
   localparam int COL_AW  = $clog2(GRID_WIDTH);
   localparam int FETCH_W = $clog2(GRID_HEIGHT + RADIUS + 1);
   localparam int CNT_W   = $clog2(NBR_MAX + 1);

   // word fields
   localparam int REQ_TYPE_W = 2;
   localparam int CELL_POS_W = 6;
   localparam int TOTAL_W    = 13;
   localparam int CFG_W      = 6;
   localparam int CMP_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // configuration port
   localparam int CSR_REGS = 4;
   localparam int CSR_AW   = $clog2(4 * CSR_REGS);
   localparam int CSR_DW   = 32;
   localparam int CSR_IW   = CSR_AW - 2;
   localparam logic [CSR_IW-1:0] CSR_SURVIVE_LOW  = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_SURVIVE_HIGH = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_BIRTH_LOW    = 2'd2;
   localparam logic [CSR_IW-1:0] CSR_BIRTH_HIGH   = 2'd3;

   // request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_WRITE = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_STEP  = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd2;

   typedef logic [GRID_WIDTH-1:0] lla_row_type;

   typedef struct packed {
      logic [CFG_W-1:0] survive_low;
      logic [CFG_W-1:0] survive_high;
      logic [CFG_W-1:0] birth_low;
      logic [CFG_W-1:0] birth_high;
   } lla_rule_type;

   typedef struct packed {
      logic clear;      // zero the row window
      logic win_shift;  // move the window down one row
      logic load;       // copy the window into the column lanes
      logic shift;      // advance one column
   } lla_cell_ctl_type;

   typedef struct packed {
      logic              en;
      logic [ROW_AW-1:0] row;
   } lla_mem_rd_type;

   typedef struct packed {
      logic              en;
      logic [ROW_AW-1:0] row;
      lla_row_type       data;
   } lla_mem_wr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_FETCH,
      ST_SHIFT,
      ST_LOAD,
      ST_SWEEP,
      ST_STORE,
      ST_RESP
   } lla_state_type;

endpackage

>>> sv/lla_req_if.sv
// Request channel: valid/ready handshake with one request word.
interface lla_req_if;
   import lla_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [CELL_POS_W-1:0] cell_row;
   logic [CELL_POS_W-1:0] cell_col;
   logic                  cell_value;

   modport source (output valid, output req_type, output cell_row, output cell_col,
                   output cell_value, input ready);
   modport sink   (input valid, input req_type, input cell_row, input cell_col,
                   input cell_value, output ready);
endinterface

>>> sv/lla_rsp_if.sv
// Response channel: valid/ready handshake with one response word.
interface lla_rsp_if;
   import lla_pkg::*;

   logic               valid;
   logic               ready;
   logic               read_value;
   logic [TOTAL_W-1:0] live_count;
   logic [TOTAL_W-1:0] dead_count;

   modport source (output valid, output read_value, output live_count, output dead_count,
                   input ready);
   modport sink   (input valid, input read_value, input live_count, input dead_count,
                   output ready);
endinterface

>>> sv/lla_csr.sv
// APB-style register block holding the survive and birth count ranges.
module lla_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [lla_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [lla_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [lla_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready,
   output lla_pkg::lla_rule_type        rule
);
   import lla_pkg::*;

   lla_rule_type      rule_ff;
   lla_rule_type      rule_in;
   logic [CSR_IW-1:0] index;
   logic              wr_en;

   assign index      = csr_paddr[CSR_AW-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign rule       = rule_ff;

   always_comb begin
      rule_in = rule_ff;
      if (wr_en) begin
         unique case (index)
            CSR_SURVIVE_LOW:  rule_in.survive_low  = csr_pwdata[CFG_W-1:0];
            CSR_SURVIVE_HIGH: rule_in.survive_high = csr_pwdata[CFG_W-1:0];
            CSR_BIRTH_LOW:    rule_in.birth_low    = csr_pwdata[CFG_W-1:0];
            CSR_BIRTH_HIGH:   rule_in.birth_high   = csr_pwdata[CFG_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_SURVIVE_LOW:  csr_prdata = CSR_DW'(rule_ff.survive_low);
         CSR_SURVIVE_HIGH: csr_prdata = CSR_DW'(rule_ff.survive_high);
         CSR_BIRTH_LOW:    csr_prdata = CSR_DW'(rule_ff.birth_low);
         CSR_BIRTH_HIGH:   csr_prdata = CSR_DW'(rule_ff.birth_high);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_ff.survive_low  <= CFG_W'(2);
         rule_ff.survive_high <= CFG_W'(3);
         rule_ff.birth_low    <= CFG_W'(3);
         rule_ff.birth_high   <= CFG_W'(3);
      end else begin
         rule_ff <= rule_in;
      end
   end
endmodule

>>> sv/lla_grid_mem.sv
// Row-wide grid memory with one read and one write port and per-row valid bits.
module lla_grid_mem (
   input  logic                    clock,
   input  logic                    reset,
   input  lla_pkg::lla_mem_rd_type rd,
   input  lla_pkg::lla_mem_wr_type wr,
   output lla_pkg::lla_row_type    rd_data
);
   import lla_pkg::*;

   lla_row_type             mem [GRID_HEIGHT];
   logic [GRID_HEIGHT-1:0]  valid_ff;
   lla_row_type             data_ff;
   logic                    hit_ff;

   // a row never written reads as all dead
   assign rd_data = hit_ff ? data_ff : '0;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.row] <= wr.data;
      end
      if (rd.en) begin
         data_ff <= mem[rd.row];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.row] <= 1'b1;
         end
         if (rd.en) begin
            hit_ff <= valid_ff[rd.row];
         end
      end
   end
endmodule

>>> sv/lla_cell_unit.sv
// Shared cell unit: row window, column lanes, neighbor count and rule check.
module lla_cell_unit (
   input  logic                      clock,
   input  lla_pkg::lla_cell_ctl_type ctl,
   input  lla_pkg::lla_row_type      row_in,
   input  lla_pkg::lla_rule_type     rule,
   output logic                      next_bit,
   output lla_pkg::lla_row_type      next_row
);
   import lla_pkg::*;

   lla_row_type        win_ff  [WIN_ROWS];
   logic [LANE_W-1:0]  lane_ff [WIN_ROWS];
   lla_row_type        next_row_ff;
   logic [CNT_W-1:0]   nbr;
   logic [CMP_W-1:0]   nbr_ext;
   logic               center;
   logic               survive;
   logic               birth;

   // taps 0..2R of each lane are the columns c-R..c+R of the current cell
   always_comb begin
      nbr = '0;
      for (int k = 0; k < WIN_ROWS; k++) begin
         for (int j = 0; j < WIN_ROWS; j++) begin
            if (!(k == RADIUS && j == RADIUS)) begin
               nbr = nbr + CNT_W'(lane_ff[k][j]);
            end
         end
      end
   end

   assign center   = lane_ff[RADIUS][RADIUS];
   assign nbr_ext  = CMP_W'(nbr);
   assign survive  = (nbr_ext >= CMP_W'(rule.survive_low)) &&
                     (nbr_ext <= CMP_W'(rule.survive_high));
   assign birth    = (nbr_ext >= CMP_W'(rule.birth_low)) &&
                     (nbr_ext <= CMP_W'(rule.birth_high));
   assign next_bit = center ? survive : birth;
   assign next_row = next_row_ff;

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         for (int k = 0; k < WIN_ROWS; k++) begin
            win_ff[k] <= '0;
         end
      end else if (ctl.win_shift) begin
         for (int k = 0; k < WIN_ROWS - 1; k++) begin
            win_ff[k] <= win_ff[k + 1];
         end
         win_ff[WIN_ROWS-1] <= row_in;
      end

      if (ctl.load) begin
         // pad with dead cells on both sides
         for (int k = 0; k < WIN_ROWS; k++) begin
            lane_ff[k] <= {{RADIUS{1'b0}}, win_ff[k], {RADIUS{1'b0}}};
         end
      end else if (ctl.shift) begin
         for (int k = 0; k < WIN_ROWS; k++) begin
            lane_ff[k] <= lane_ff[k] >> 1;
         end
      end

      if (ctl.shift) begin
         next_row_ff <= {next_bit, next_row_ff[GRID_WIDTH-1:1]};
      end
   end
endmodule

>>> sv/life_like_automaton_step_unit.sv
// Life-like automaton step unit. Holds a 64 x 64 grid of one-bit cells (all dead after
// reset) in a row-wide memory and serves one request word at a time: write a cell, read
// a cell, or compute the next generation of the whole grid, with neighbors taken from the
// square of radius RADIUS around each cell, no wrap at the edges, and survive/birth ranges
// from the four registers. Every request returns one response word carrying the read bit
// and the live and dead totals of the last generation. A step runs one cell per cycle
// through a single neighbor-count and rule unit fed by a window of 2*RADIUS+1 rows;
// each row goes through the fetch of its missing window rows from memory, window load,
// column sweep and row write-back. The request channel is not ready while a request is
// in progress; a finished response waits in an output register and does not block the
// next request.
module life_like_automaton_step_unit (
   input  logic                        clock,
   input  logic                        reset,
   lla_req_if.sink                     req_chan,
   lla_rsp_if.source                   rsp_chan,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [lla_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [lla_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [lla_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import lla_pkg::*;

   lla_state_type          state_ff, state_in;
   logic [REQ_TYPE_W-1:0]  op_ff, op_in;
   logic [ROW_AW-1:0]      cell_row_ff, cell_row_in;
   logic [COL_AW-1:0]      cell_col_ff, cell_col_in;
   logic                   value_ff, value_in;
   logic                   inside_ff, inside_in;
   logic                   rd_bit_ff, rd_bit_in;
   logic [ROW_AW-1:0]      cur_row_ff, cur_row_in;
   logic [FETCH_W-1:0]     fetch_ff, fetch_in;
   logic [COL_AW-1:0]      sweep_col_ff, sweep_col_in;
   logic [TOTAL_W-1:0]     live_acc_ff, live_acc_in;
   logic [TOTAL_W-1:0]     dead_acc_ff, dead_acc_in;
   logic [TOTAL_W-1:0]     live_total_ff, live_total_in;
   logic [TOTAL_W-1:0]     dead_total_ff, dead_total_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_read_ff, rsp_read_in;
   logic [TOTAL_W-1:0]     rsp_live_ff, rsp_live_in;
   logic [TOTAL_W-1:0]     rsp_dead_ff, rsp_dead_in;

   lla_rule_type           rule;
   lla_mem_rd_type         mem_rd;
   lla_mem_wr_type         mem_wr;
   lla_row_type            mem_rd_data;
   lla_row_type            row_in;
   lla_row_type            next_row;
   lla_row_type            patched_row;
   lla_cell_ctl_type       cell_ctl;
   logic                   next_bit;
   logic                   req_inside;
   logic                   fetch_in_grid;

   lla_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .rule        (rule)
   );

   lla_grid_mem u_grid_mem (
      .clock   (clock),
      .reset   (reset),
      .rd      (mem_rd),
      .wr      (mem_wr),
      .rd_data (mem_rd_data)
   );

   lla_cell_unit u_cell_unit (
      .clock    (clock),
      .ctl      (cell_ctl),
      .row_in   (row_in),
      .rule     (rule),
      .next_bit (next_bit),
      .next_row (next_row)
   );

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_value = rsp_read_ff;
   assign rsp_chan.live_count = rsp_live_ff;
   assign rsp_chan.dead_count = rsp_dead_ff;

   assign req_inside    = (int'(req_chan.cell_row) < GRID_HEIGHT) &&
                          (int'(req_chan.cell_col) < GRID_WIDTH);
   assign fetch_in_grid = (int'(fetch_ff) < GRID_HEIGHT);
   // rows below the grid enter the window as dead
   assign row_in        = fetch_in_grid ? mem_rd_data : '0;

   always_comb begin
      patched_row              = mem_rd_data;
      patched_row[cell_col_ff] = value_ff;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      cell_row_in   = cell_row_ff;
      cell_col_in   = cell_col_ff;
      value_in      = value_ff;
      inside_in     = inside_ff;
      rd_bit_in     = rd_bit_ff;
      cur_row_in    = cur_row_ff;
      fetch_in      = fetch_ff;
      sweep_col_in  = sweep_col_ff;
      live_acc_in   = live_acc_ff;
      dead_acc_in   = dead_acc_ff;
      live_total_in = live_total_ff;
      dead_total_in = dead_total_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_chan.ready;
      rsp_read_in   = rsp_read_ff;
      rsp_live_in   = rsp_live_ff;
      rsp_dead_in   = rsp_dead_ff;
      mem_rd        = '0;
      mem_wr        = '0;
      cell_ctl      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               op_in       = req_chan.req_type;
               cell_row_in = ROW_AW'(req_chan.cell_row);
               cell_col_in = COL_AW'(req_chan.cell_col);
               value_in    = req_chan.cell_value;
               inside_in   = req_inside;
               rd_bit_in   = 1'b0;
               mem_rd.row  = ROW_AW'(req_chan.cell_row);
               unique case (req_chan.req_type)
                  REQ_WRITE: begin
                     mem_rd.en = 1'b1;
                     state_in  = ST_WRITE;
                  end
                  REQ_READ: begin
                     mem_rd.en = 1'b1;
                     state_in  = ST_READ;
                  end
                  REQ_STEP: begin
                     cell_ctl.clear = 1'b1;
                     cur_row_in     = '0;
                     fetch_in       = '0;
                     live_acc_in    = '0;
                     dead_acc_in    = '0;
                     state_in       = ST_FETCH;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         ST_WRITE: begin
            mem_wr.en   = inside_ff;
            mem_wr.row  = cell_row_ff;
            mem_wr.data = patched_row;
            state_in    = ST_RESP;
         end

         ST_READ: begin
            rd_bit_in = inside_ff & mem_rd_data[cell_col_ff];
            state_in  = ST_RESP;
         end

         ST_FETCH: begin
            mem_rd.en  = fetch_in_grid;
            mem_rd.row = fetch_ff[ROW_AW-1:0];
            state_in   = ST_SHIFT;
         end

         ST_SHIFT: begin
            cell_ctl.win_shift = 1'b1;
            fetch_in           = fetch_ff + FETCH_W'(1);
            // window is complete once it reaches RADIUS rows past the current one
            if (fetch_ff == FETCH_W'(cur_row_ff) + FETCH_W'(RADIUS)) begin
               state_in = ST_LOAD;
            end else begin
               state_in = ST_FETCH;
            end
         end

         ST_LOAD: begin
            cell_ctl.load = 1'b1;
            sweep_col_in  = '0;
            state_in      = ST_SWEEP;
         end

         ST_SWEEP: begin
            cell_ctl.shift = 1'b1;
            if (next_bit) begin
               if (live_acc_ff != TOTAL_MAX) begin
                  live_acc_in = live_acc_ff + TOTAL_W'(1);
               end
            end else begin
               if (dead_acc_ff != TOTAL_MAX) begin
                  dead_acc_in = dead_acc_ff + TOTAL_W'(1);
               end
            end
            sweep_col_in = sweep_col_ff + COL_AW'(1);
            if (sweep_col_ff == COL_AW'(GRID_WIDTH - 1)) begin
               state_in = ST_STORE;
            end
         end

         ST_STORE: begin
            // rows above stay in the window, so write back in place
            mem_wr.en   = 1'b1;
            mem_wr.row  = cur_row_ff;
            mem_wr.data = next_row;
            if (cur_row_ff == ROW_AW'(GRID_HEIGHT - 1)) begin
               live_total_in = live_acc_ff;
               dead_total_in = dead_acc_ff;
               state_in      = ST_RESP;
            end else begin
               cur_row_in = cur_row_ff + ROW_AW'(1);
               state_in   = ST_FETCH;
            end
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_read_in  = rd_bit_ff;
               rsp_live_in  = live_total_ff;
               rsp_dead_in  = dead_total_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         live_total_ff <= '0;
         dead_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         live_total_ff <= live_total_in;
         dead_total_ff <= dead_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      cell_row_ff  <= cell_row_in;
      cell_col_ff  <= cell_col_in;
      value_ff     <= value_in;
      inside_ff    <= inside_in;
      rd_bit_ff    <= rd_bit_in;
      cur_row_ff   <= cur_row_in;
      fetch_ff     <= fetch_in;
      sweep_col_ff <= sweep_col_in;
      live_acc_ff  <= live_acc_in;
      dead_acc_ff  <= dead_acc_in;
      rsp_read_ff  <= rsp_read_in;
      rsp_live_ff  <= rsp_live_in;
      rsp_dead_ff  <= rsp_dead_in;
   end

`ifndef SYNTHESIS
   a_window_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |->
         (fetch_ff == FETCH_W'(cur_row_ff) + FETCH_W'(RADIUS + 1)))
      else $error("row window loaded before it holds all rows of the neighborhood");

   a_full_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STORE) |->
         ($past(state_ff) == ST_SWEEP && $past(sweep_col_ff) == COL_AW'(GRID_WIDTH - 1)))
      else $error("row written back before the column sweep finished");

   a_totals_cover_grid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && op_ff == REQ_STEP) |->
         ((CELLS > int'(TOTAL_MAX)) ||
          ((TOTAL_W + 1)'(live_total_ff) + (TOTAL_W + 1)'(dead_total_ff) ==
           (TOTAL_W + 1)'(CELLS))))
      else $error("live and dead totals do not add up to the grid size");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RESP))
      else $error("response word raised outside the response state");
`endif
endmodule
